// ===== rtl/core/rhc_pkg.sv =====
package rhc_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned QuoW  = 16;
  localparam int unsigned DenW  = 11;
  localparam int unsigned NumW  = 12;
  localparam int unsigned Steps = 16;

  typedef struct packed {
    logic [DenW-1:0] rem_h;
    logic [QuoW-1:0] q_h;
    logic [PixW-1:0] rem_s;
    logic [QuoW-1:0] q_s;
    logic [DenW-1:0] den;
    logic [PixW-1:0] mx;
    logic            zero;
  } div_stage_t;

endpackage

// ===== rtl/core/rgb_to_hsv_converter_top.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o  | red_i, green_i, blue_i
// out     | output    | out_valid_o / out_ready_i| hue_o, saturation_o, brightness_o
//
// One transaction per cycle sustained while the output is not stalled.
// The pipeline is the two 16-step restoring dividers, one quotient bit per stage,
// behind one stage that finds max, min, delta and the hue numerator.
// rst_ni clears only the stage valid bits.
// A stall at the output freezes the whole pipeline; in_ready_o drops with it.
module rgb_to_hsv_converter_top
  import rhc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      red_i,
  input  logic [7:0]      green_i,
  input  logic [7:0]      blue_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     hue_o,
  output logic [15:0]     saturation_o,
  output logic [7:0]      brightness_o
);

  logic             en;
  logic [Steps:0]   v_q;
  div_stage_t       st_q [Steps+1];
  div_stage_t       st_d [Steps+1];

  assign en         = !v_q[Steps] || out_ready_i;
  assign in_ready_o = en;

  // prep stage
  logic [PixW-1:0]        mx, mn, delta;
  logic [DenW-1:0]        den;
  logic signed [NumW-1:0] num;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i > mx) mx = blue_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;
    den   = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    if (red_i == mx) begin
      num = $signed({4'b0, green_i}) - $signed({4'b0, blue_i});
      if (num < 0) num = num + $signed({1'b0, den});
    end else if (green_i == mx) begin
      num = $signed({3'b0, delta, 1'b0}) + $signed({4'b0, blue_i})
          - $signed({4'b0, red_i});
    end else begin
      num = $signed({2'b0, delta, 2'b0}) + $signed({4'b0, red_i})
          - $signed({4'b0, green_i});
    end
    st_d[0].rem_h = num[DenW-1:0];
    st_d[0].q_h   = '0;
    st_d[0].rem_s = delta;
    st_d[0].q_s   = '0;
    st_d[0].den   = den;
    st_d[0].mx    = mx;
    st_d[0].zero  = (delta == '0);
  end

  for (genvar k = 0; k < Steps; k++) begin : g_div
    logic [DenW:0]   h2;
    logic [PixW:0]   s2;
    logic            bh, bs;
    always_comb begin
      st_d[k+1] = st_q[k];
      h2 = {st_q[k].rem_h, 1'b0};
      if (k == 0) s2 = {1'b0, st_q[k].rem_s};
      else        s2 = {st_q[k].rem_s, 1'b0};
      bh = (h2 >= {1'b0, st_q[k].den});
      bs = (s2 >= {1'b0, st_q[k].mx});
      if (bh) h2 = h2 - {1'b0, st_q[k].den};
      if (bs) s2 = s2 - {1'b0, st_q[k].mx};
      st_d[k+1].rem_h = h2[DenW-1:0];
      st_d[k+1].rem_s = s2[PixW-1:0];
      st_d[k+1].q_h   = {st_q[k].q_h[QuoW-2:0], bh};
      st_d[k+1].q_s   = {st_q[k].q_s[QuoW-2:0], bs};
      if (k == Steps-1 && st_q[k].zero) begin
        st_d[k+1].q_h = '0;
        st_d[k+1].q_s = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Steps-1:0], in_valid_i};
    end
  end

  for (genvar k = 0; k <= Steps; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_valid_o  = v_q[Steps];
  assign hue_o        = st_q[Steps].q_h;
  assign saturation_o = st_q[Steps].q_s;
  assign brightness_o = st_q[Steps].mx;

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> saturation_o <= 16'd32768)
    else $error("saturation above one");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && brightness_o == 8'd0) |-> (saturation_o == 16'd0 && hue_o == 16'd0))
    else $error("black pixel with nonzero hue or saturation");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow output stall");

endmodule

// ===== verif/rgb_to_hsv_converter_checker.sv =====
`timescale 1ns / 1ps

module rgb_to_hsv_converter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] hue_i,
  input  logic [15:0] saturation_i,
  input  logic [7:0]  brightness_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] sat;
    logic [7:0]  val;
  } hsv_t;

  hsv_t hsv_queue[$];

  function automatic hsv_t rgb_to_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsv_t        res;
    int unsigned mx;
    int unsigned mn;
    int unsigned dl;
    int          num;
    int          den;
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    dl = mx - mn;
    res.val = mx[7:0];
    res.sat = '0;
    res.hue = '0;
    if (mx != 0 && dl != 0) begin
      res.sat = 16'((dl * 32768) / mx);
      den = 6 * dl;
      if (r == mx) num = int'(g) - int'(b);
      else if (g == mx) num = 2 * dl + int'(b) - int'(r);
      else num = 4 * dl + int'(r) - int'(g);
      if (num < 0) num += den;
      res.hue = 16'((num * 65536) / den);
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    hsv_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) hsv_queue.push_back(rgb_to_hsv(red_i, green_i, blue_i));
      if (out_valid_i && out_ready_i) begin
        if (hsv_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected transaction h=%0d s=%0d v=%0d",
                                          hue_i, saturation_i, brightness_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = hsv_queue.pop_front();
          if (want.hue !== hue_i || want.sat !== saturation_i || want.val !== brightness_i)
          begin
            if (fail_count_o < 10)
              $display("mismatch: exp h=%0d s=%0d v=%0d got h=%0d s=%0d v=%0d",
                       want.hue, want.sat, want.val, hue_i, saturation_i, brightness_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = hsv_queue.size();

endmodule

// ===== verif/rgb_to_hsv_converter_top_tb.sv =====
`timescale 1ns / 1ps

module rgb_to_hsv_converter_top_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  red_i = '0;
  logic [7:0]  green_i = '0;
  logic [7:0]  blue_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] hue_o;
  logic [15:0] saturation_o;
  logic [7:0]  brightness_o;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 20;
  int          recv_idle_pct = 50;
  int          quiet_cycles = 0;
  int          pixel_count = 0;

  localparam int WatchdogLimit = 2000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rgb_to_hsv_converter_top u_top (.*);

  rgb_to_hsv_converter_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .red_i, .green_i, .blue_i,
    .out_valid_i(out_valid_o), .out_ready_i, .hue_i(hue_o), .saturation_i(saturation_o),
    .brightness_i(brightness_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("watchdog: no progress");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    @(posedge clk_i iff in_ready_o);
    @(negedge clk_i);
    pixel_count++;
  endtask

  task automatic random_pixel();
    logic [7:0] r, g, b, lvl;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    lvl = 8'($urandom);
    case ($urandom_range(5))
      0: send_pixel(lvl, lvl, lvl);
      1: send_pixel(lvl, lvl, b);
      2: send_pixel(r, lvl, lvl);
      3: send_pixel(lvl, g, lvl);
      default: send_pixel(r, g, b);
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd1, 8'd0, 8'd1);
    send_pixel(8'd200, 8'd10, 8'd200);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd0, 8'd1, 8'd2);
    send_pixel(8'd2, 8'd1, 8'd0);
    send_pixel(8'd255, 8'd1, 8'd0);
    in_valid_i <= 1'b0;
    // let the pipeline drain fully before the random part
    while (pending != 0) @(negedge clk_i);
    for (int i = 0; i < 600; i++) random_pixel();
    send_idle_pct = 50;
    recv_idle_pct = 20;
    for (int i = 0; i < 600; i++) random_pixel();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 600; i++) random_pixel();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("sent %0d pixels: black, grey, primaries, max ties and random RGB", pixel_count);
    $display("with sender and receiver stalls in both ratios and at full rate");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rhc_pkg.sv
rtl/core/rgb_to_hsv_converter_top.sv
verif/rgb_to_hsv_converter_checker.sv
verif/rgb_to_hsv_converter_top_tb.sv
